// ----- rtl/wbm_pkg.sv -----
// shared constants, types and helpers for the word blacklist masker
`timescale 1ns / 1ps

package wbm_pkg;

    localparam int NUM_ENTRIES  = 256;
    localparam int MAX_WORD_LEN = 32;
    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int SW = $clog2(NUM_ENTRIES + 1);
    localparam int CW = $clog2(MAX_WORD_LEN + 1);
    localparam int IW = $clog2(MAX_WORD_LEN);

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [2:0] MASK_LEN = 3'd5;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WORD, S_TAIL} state_t;

    typedef struct packed {
        logic       vld;
        logic [5:0] len;
    } row_info_t;

    typedef struct packed {
        logic            wr;
        logic [AW-1:0]   addr;
        logic [IW-1:0]   pos;
        logic            char_wr;
        logic [7:0]      char_val;
        logic [5:0]      len;
    } tbl_wr_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        is_delim = (c == CH_SP) || (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

// ----- rtl/wbm_cell.sv -----
// one word buffer cell: holds a byte, shifts toward the output, compares with a table char
`timescale 1ns / 1ps

module wbm_cell
    import wbm_pkg::*;
(
    input  logic       clk,
    input  logic       wr,
    input  logic [7:0] din,
    input  logic       shift,
    input  logic [7:0] shift_in,
    input  logic [7:0] row_char,
    output logic [7:0] q,
    output logic       eq
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= shift_in;
        end
        else if (wr)
        begin
            byte_reg <= din;
        end
    end

    assign q  = byte_reg;
    assign eq = (to_lower(byte_reg) == row_char);

endmodule

// ----- rtl/wbm_table.sv -----
// word table: one row of characters per entry with length and valid bits
`timescale 1ns / 1ps

module wbm_table
    import wbm_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tbl_wr_t                         wr,
    input  logic                            rd,
    input  logic [AW-1:0]                   rd_addr,
    output logic [MAX_WORD_LEN-1:0][7:0]    row,
    output row_info_t                       info
);

    logic [MAX_WORD_LEN-1:0][7:0] chars_mem [NUM_ENTRIES];
    logic [5:0]                   len_mem   [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0]       vld_reg;
    logic [5:0]                   len_q;
    logic                         vld_q;

    always_ff @(posedge clk)
    begin
        if (wr.wr)
        begin
            len_mem[wr.addr] <= wr.len;
            if (wr.char_wr)
            begin
                chars_mem[wr.addr][wr.pos] <= wr.char_val;
            end
        end
        if (rd)
        begin
            row   <= chars_mem[rd_addr];
            len_q <= len_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vld_q   <= 1'b0;
        end
        else
        begin
            if (wr.wr)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd)
            begin
                vld_q <= vld_reg[rd_addr];
            end
        end
    end

    assign info.vld = vld_q;
    assign info.len = vld_q ? len_q : 6'd0;

endmodule

// ----- rtl/word_blacklist_masker_top.sv -----
// top level of the word blacklist masker
`timescale 1ns / 1ps

// Text bytes (tuser = 0) are gathered into a row of buffer cells until a
// delimiter or tlast ends the word; load items (tuser = 1) write one table
// character and the entry length. A finished word scans the table one
// entry per cycle through the single read port of the row memory, then
// emits its bytes, which stall while the receiver holds m_tready low.
// Words that overflow the buffer, and delimiters after an empty word,
// skip the scan and go straight to emitting their bytes. No clearing pass
// is needed after reset.
module word_blacklist_masker_top
    import wbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // text_byte[7:0], entry_index[15:8], char_index[20:16], load_char[28:21],
    // entry_length[34:29], zero[39:35]
    input  logic [39:0] s_tdata,
    // cmd
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte
    output logic [7:0]  m_tdata,
    // word_masked[0], word_too_long[1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next, rem_reg, rem_next;
    logic pass_reg, pass_next, masked_reg, masked_next, long_reg, long_next;
    logic [7:0] tail_reg, tail_next;
    logic tail_vld_reg, tail_vld_next, tail_long_reg, tail_long_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic cmp_vld_reg, cmp_vld_next, found_reg, found_next;
    logic out_vld_reg, out_vld_next, out_last_reg, out_last_next;
    logic out_mask_reg, out_mask_next, out_long_reg, out_long_next;
    logic [7:0] out_byte_reg, out_byte_next;

    logic [7:0] text_byte;
    logic accept, slot_free, rd, shift, buf_wr, match;
    logic [31:0] ei_ext, ci_ext;
    tbl_wr_t tw;
    row_info_t info;
    logic [MAX_WORD_LEN-1:0][7:0] row;
    logic [MAX_WORD_LEN-1:0][7:0] cell_q;
    logic [MAX_WORD_LEN-1:0] cell_eq, cell_ok;

    assign text_byte = s_tdata[7:0];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_vld_reg || m_tready;
    assign ei_ext    = {24'd0, s_tdata[15:8]};
    assign ci_ext    = {27'd0, s_tdata[20:16]};

    always_comb
    begin
        tw.wr       = accept && s_tuser && (ei_ext < 32'(NUM_ENTRIES));
        tw.addr     = ei_ext[AW-1:0];
        tw.pos      = ci_ext[IW-1:0];
        tw.char_wr  = (ci_ext < 32'(MAX_WORD_LEN));
        tw.char_val = s_tdata[28:21];
        tw.len      = s_tdata[34:29];
    end

    wbm_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tw),
        .rd      (rd),
        .rd_addr (scan_reg[AW-1:0]),
        .row     (row),
        .info    (info)
    );

    genvar g;
    generate
        for (g = 0; g < MAX_WORD_LEN; g++)
        begin : g_cell
            logic [7:0] nxt;
            if (g == MAX_WORD_LEN - 1)
            begin : g_end
                assign nxt = 8'd0;
            end
            else
            begin : g_mid
                assign nxt = cell_q[g + 1];
            end
            wbm_cell u_cell (
                .clk      (clk),
                .wr       (buf_wr && (count_reg == CW'(g))),
                .din      (text_byte),
                .shift    (shift),
                .shift_in (nxt),
                .row_char (row[g]),
                .q        (cell_q[g]),
                .eq       (cell_eq[g])
            );
            assign cell_ok[g] = cell_eq[g] || (CW'(g) >= count_reg);
        end
    endgenerate

    assign match = (info.len == 6'(count_reg)) && (&cell_ok);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        pass_next      = pass_reg;
        masked_next    = masked_reg;
        long_next      = long_reg;
        tail_next      = tail_reg;
        tail_vld_next  = tail_vld_reg;
        tail_long_next = tail_long_reg;
        scan_next      = scan_reg;
        cmp_vld_next   = 1'b0;
        found_next     = found_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_mask_next  = out_mask_reg;
        out_long_next  = out_long_reg;
        rd             = 1'b0;
        shift          = 1'b0;
        buf_wr         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !s_tuser)
                begin
                    tail_next     = text_byte;
                    scan_next     = '0;
                    found_next    = 1'b0;
                    masked_next   = 1'b0;
                    long_next     = 1'b0;
                    if (is_delim(text_byte))
                    begin
                        tail_vld_next  = 1'b1;
                        tail_long_next = 1'b0;
                        pass_next      = 1'b0;
                        if (!pass_reg && count_reg != '0)
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            count_next = '0;
                            state_next = S_TAIL;
                        end
                    end
                    else if (pass_reg)
                    begin
                        tail_vld_next  = 1'b1;
                        tail_long_next = 1'b1;
                        pass_next      = !s_tlast;
                        state_next     = S_TAIL;
                    end
                    else if (count_reg >= CW'(MAX_WORD_LEN))
                    begin
                        tail_vld_next  = 1'b1;
                        tail_long_next = 1'b1;
                        long_next      = 1'b1;
                        rem_next       = count_reg;
                        pass_next      = !s_tlast;
                        state_next     = S_WORD;
                    end
                    else
                    begin
                        buf_wr        = 1'b1;
                        count_next    = count_reg + 1'b1;
                        tail_vld_next = 1'b0;
                        if (s_tlast)
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_reg < SW'(NUM_ENTRIES))
                begin
                    rd           = 1'b1;
                    cmp_vld_next = 1'b1;
                    scan_next    = scan_reg + 1'b1;
                end
                if (cmp_vld_reg && match)
                begin
                    found_next = 1'b1;
                end
                if (scan_reg == SW'(NUM_ENTRIES) && !cmp_vld_reg)
                begin
                    masked_next = found_reg;
                    rem_next    = found_reg ? CW'(MASK_LEN) : count_reg;
                    state_next  = S_WORD;
                end
            end
            S_WORD:
            begin
                if (slot_free)
                begin
                    out_vld_next  = 1'b1;
                    out_byte_next = masked_reg ? CH_STAR : cell_q[0];
                    out_mask_next = masked_reg;
                    out_long_next = long_reg;
                    out_last_next = (rem_reg == CW'(1)) && !tail_vld_reg;
                    shift         = !masked_reg;
                    rem_next      = rem_reg - 1'b1;
                    if (rem_reg == CW'(1))
                    begin
                        count_next = '0;
                        state_next = tail_vld_reg ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL:
            begin
                if (slot_free)
                begin
                    out_vld_next  = 1'b1;
                    out_byte_next = tail_reg;
                    out_mask_next = 1'b0;
                    out_long_next = tail_long_reg;
                    out_last_next = 1'b1;
                    tail_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pass_reg     <= 1'b0;
            tail_vld_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pass_reg     <= pass_next;
            tail_vld_reg <= tail_vld_next;
            cmp_vld_reg  <= cmp_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        masked_reg    <= masked_next;
        long_reg      <= long_next;
        tail_reg      <= tail_next;
        tail_long_reg <= tail_long_next;
        scan_reg      <= scan_next;
        found_reg     <= found_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_mask_reg  <= out_mask_next;
        out_long_reg  <= out_long_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_long_reg, out_mask_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/wbm_checker.sv -----
// port-level checker for the word blacklist masker, bound to the top level
`timescale 1ns / 1ps

module wbm_checker
    import wbm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output dropped while stalled");

    a_star: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == CH_STAR)
        else $error("masked byte is not an asterisk");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("byte both masked and too long");

    a_delim: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != 2'b00) |-> !is_delim(m_tdata))
        else $error("flagged delimiter");

endmodule

bind word_blacklist_masker_top wbm_checker u_wbm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- dv/tb_top.sv -----
// self-checking testbench for the word blacklist masker top level
`timescale 1ns / 1ps

module tb_top;
    import wbm_pkg::*;

    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_LOAD = 1'b1;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic       cmd;
        logic [7:0] text_byte;
        logic       eot;
        logic [7:0] entry;
        logic [4:0] pos;
        logic [7:0] chr;
        logic [5:0] len;
    } txn_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       masked;
        logic       too_long;
    } out_t;

    typedef struct {
        txn_t in;
        logic chk;
        out_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    logic [7:0] lut_chars [NUM_ENTRIES][MAX_WORD_LEN];
    logic [5:0] lut_len [NUM_ENTRIES];
    logic [7:0] word_q [MAX_WORD_LEN];
    int         word_len;
    logic       pass_mode;

    out_t       expected_bytes [$];
    txn_t       sent_q [$];
    int         errors;
    int         idle_cnt;
    int         n_masked;
    int         n_long;
    int         n_bytes;
    logic       quiet;
    logic       hold_rx;
    logic       stop_idle;
    row_t       dir_rows [$];
    int         accepted;

    word_blacklist_masker_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic delim(input logic [7:0] c);
        return c == CH_SP || c == CH_NUL || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic [7:0] lc(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    task automatic emit_byte(input logic [7:0] c, input logic m, input logic t);
        out_t o;
        o.ch = c;
        o.last = 1'b0;
        o.masked = m;
        o.too_long = t;
        expected_bytes.push_back(o);
    endtask

    function automatic logic word_listed();
        logic hit;
        hit = 1'b0;
        for (int j = 0; j < NUM_ENTRIES; j++)
        begin
            if (lut_len[j] == word_len)
            begin
                logic eq;
                eq = 1'b1;
                for (int i = 0; i < word_len; i++)
                    if (lut_chars[j][i] != lc(word_q[i]))
                        eq = 1'b0;
                if (eq)
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic flush_word();
        if (word_len > 0)
        begin
            if (word_listed())
                for (int i = 0; i < 5; i++)
                    emit_byte(CH_STAR, 1'b1, 1'b0);
            else
                for (int i = 0; i < word_len; i++)
                    emit_byte(word_q[i], 1'b0, 1'b0);
        end
        word_len = 0;
        pass_mode = 1'b0;
    endtask

    task automatic predict_masking(input txn_t t);
        int prev_size;
        prev_size = expected_bytes.size();
        if (t.cmd == CMD_LOAD)
        begin
            lut_len[t.entry] = t.len;
            lut_chars[t.entry][t.pos] = t.chr;
            return;
        end
        if (delim(t.text_byte))
        begin
            if (!pass_mode)
                flush_word();
            word_len = 0;
            pass_mode = 1'b0;
            emit_byte(t.text_byte, 1'b0, 1'b0);
        end
        else
        begin
            if (pass_mode)
                emit_byte(t.text_byte, 1'b0, 1'b1);
            else if (word_len >= MAX_WORD_LEN)
            begin
                for (int i = 0; i < MAX_WORD_LEN; i++)
                    emit_byte(word_q[i], 1'b0, 1'b1);
                emit_byte(t.text_byte, 1'b0, 1'b1);
                word_len = 0;
                pass_mode = 1'b1;
            end
            else
            begin
                word_q[word_len] = t.text_byte;
                word_len++;
            end
            if (t.eot)
            begin
                if (!pass_mode)
                    flush_word();
                word_len = 0;
                pass_mode = 1'b0;
            end
        end
        if (expected_bytes.size() > prev_size)
            expected_bytes[$].last = 1'b1;
    endtask

    function automatic txn_t text_txn(input logic [7:0] c, input logic e);
        txn_t t;
        t = '0;
        t.cmd = CMD_TEXT;
        t.text_byte = c;
        t.eot = e;
        t.entry = 8'($urandom);
        t.pos = 5'($urandom);
        t.chr = 8'($urandom);
        t.len = 6'($urandom);
        return t;
    endfunction

    function automatic txn_t load_txn(input int e, input int p, input logic [7:0] c,
                                      input int n);
        txn_t t;
        t = '0;
        t.cmd = CMD_LOAD;
        t.entry = 8'(e);
        t.pos = 5'(p);
        t.chr = c;
        t.len = 6'(n);
        t.text_byte = 8'($urandom);
        t.eot = 1'($urandom);
        return t;
    endfunction

    // loaded-position bookkeeping: marks the table characters written by the directed and blacklist loads
    logic [MAX_WORD_LEN-1:0] written [NUM_ENTRIES];

    task automatic send(input txn_t t);
        if (!stop_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_tdata <= {5'b0, t.len, t.chr, t.pos, t.entry, t.text_byte};
        s_tuser <= t.cmd;
        s_tlast <= t.eot;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_masking(t);
        accepted++;
        @(negedge clk);
    endtask

    task automatic load_word(input int e, input string w);
        for (int i = 0; i < w.len(); i++)
        begin
            send(load_txn(e, i, w[i], w.len()));
            written[e][i] = 1'b1;
        end
    endtask

    task automatic send_text(input string w, input logic [7:0] d, input logic e);
        for (int i = 0; i < w.len(); i++)
            send(text_txn(w[i], e && d == 8'hFF && i == w.len() - 1));
        if (d != 8'hFF)
            send(text_txn(d, e));
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (NUM_ENTRIES + 10) @(negedge clk);
    endtask

    // output side
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output transaction byte %h", m_tdata);
                errors++;
            end
            else
            begin
                out_t x;
                x = expected_bytes.pop_front();
                n_bytes++;
                if (x.masked)
                    n_masked++;
                if (x.too_long)
                    n_long++;
                if (m_tdata !== x.ch)
                begin
                    $error("out_byte expected %h actual %h", x.ch, m_tdata);
                    errors++;
                end
                if (m_tlast !== x.last)
                begin
                    $error("last_of_run expected %b actual %b", x.last, m_tlast);
                    errors++;
                end
                if (m_tuser[0] !== x.masked)
                begin
                    $error("word_masked expected %b actual %b", x.masked, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== x.too_long)
                begin
                    $error("word_too_long expected %b actual %b", x.too_long,
                           m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_rx = 1'b0;
            end
            else if (!stop_idle && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // watchdog on accepted transactions
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n || quiet)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT)
        begin
            $display("word_blacklist_masker_top verification failed");
            $finish;
        end
    end

    initial
    begin
        txn_t t;
        string w;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        errors = 0;
        n_masked = 0;
        n_long = 0;
        n_bytes = 0;
        accepted = 0;
        quiet = 1'b1;
        hold_rx = 1'b0;
        stop_idle = 1'b0;
        word_len = 0;
        pass_mode = 1'b0;
        for (int j = 0; j < NUM_ENTRIES; j++)
        begin
            lut_len[j] = '0;
            written[j] = '0;
            for (int i = 0; i < MAX_WORD_LEN; i++)
                lut_chars[j][i] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        quiet = 1'b0;

        // directed table: empty-word delimiters, a short word, extremes
        dir_rows.push_back('{text_txn(CH_SP, 1'b0), 1'b1, '{CH_SP, 1'b1, 1'b0, 1'b0}});
        dir_rows.push_back('{text_txn(CH_NUL, 1'b0), 1'b1, '{CH_NUL, 1'b1, 1'b0, 1'b0}});
        dir_rows.push_back('{text_txn(CH_CR, 1'b1), 1'b1, '{CH_CR, 1'b1, 1'b0, 1'b0}});
        dir_rows.push_back('{text_txn(CH_LF, 1'b0), 1'b1, '{CH_LF, 1'b1, 1'b0, 1'b0}});
        dir_rows.push_back('{text_txn(8'hFF, 1'b1), 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}});
        dir_rows.push_back('{text_txn("Q", 1'b0), 1'b0, '0});
        dir_rows.push_back('{text_txn(CH_SP, 1'b0), 1'b0, '0});
        foreach (dir_rows[k])
        begin
            send(dir_rows[k].in);
            if (dir_rows[k].chk)
            begin
                out_t e;
                e = dir_rows[k].res;
                if (expected_bytes.size() == 0 || expected_bytes[$] != e)
                begin
                    $error("directed row %0d expected %h predicted differently",
                           k, e.ch);
                    errors++;
                end
            end
        end
        // table loads, extremes of entry and length, highest character position
        load_word(0, "bad");
        load_word(255, "x");
        load_word(7, "aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa");
        send(load_txn(9, 31, 8'hFF, 63));
        written[9][31] = 1'b1;
        send_text("BaD", CH_SP, 1'b0);
        send_text("bad", 8'hFF, 1'b1);
        send_text("X", CH_LF, 1'b0);
        send_text("AAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA", CH_CR, 1'b0);
        send_text("overflowingwordthatistoolongforbuffer", CH_SP, 1'b0);
        send_text("longlonglonglonglonglonglonglongz", 8'hFF, 1'b1);
        quiesce();

        // receiver hold-off with the sender pushing on
        hold_rx = 1'b1;
        for (int k = 0; k < 15; k++)
            send(text_txn(k % 3 == 2 ? CH_SP : 8'h61 + 8'(k % 26), 1'b0));
        quiesce();

        // random part: mostly words, some loaded as blacklist, some noise
        for (int k = 0; k < 5; k++)
        begin
            int n;
            int e;
            if (k == 3)
                stop_idle = 1'b1;
            n = $urandom_range(0, 5) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 6);
            w = "";
            for (int i = 0; i < n; i++)
            begin
                logic [7:0] c;
                c = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h61 + 8'($urandom_range(0, 3));
                if (delim(c))
                    c = "b";
                w = {w, string'(c)};
            end
            if (n <= MAX_WORD_LEN && $urandom_range(0, 2) == 0)
            begin
                e = $urandom_range(1, 254);
                // the load writes every position below n of the chosen entry
                load_word(e, w.tolower());
            end
            if ($urandom_range(0, 1))
                for (int i = 0; i < n; i++)
                    if ($urandom_range(0, 1))
                        w[i] = lc(w[i]) == w[i] && w[i] >= "a" && w[i] <= "z" ?
                               w[i] - 8'd32 : w[i];
            case ($urandom_range(0, 4))
                0: send_text(w, CH_SP, 1'b0);
                1: send_text(w, CH_NUL, 1'b0);
                2: send_text(w, CH_CR, 1'($urandom_range(0, 1)));
                3: send_text(w, CH_LF, 1'b0);
                default: send_text(w, 8'hFF, 1'b1);
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                // noise load that never makes an entry with unwritten positions matchable
                t = load_txn($urandom_range(0, 255), $urandom_range(0, 31), 8'($urandom), 0);
                send(t);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (NUM_ENTRIES + 10) @(negedge clk);
        $display("covered %0d input transactions, %0d output bytes", accepted, n_bytes);
        $display("masked bytes %0d, overflow bytes %0d", n_masked, n_long);
        if (errors == 0)
            $display("word_blacklist_masker_top verification clean");
        else
            $display("word_blacklist_masker_top verification failed");
        $finish;
    end

endmodule
